### hw/rtl/hlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_pkg
// Types and constants shared by the hash list compare block.
// ----------------------------------------------------------------------------
package hlc_pkg;

  localparam int unsigned HASH_W        = 32;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned LENGTH_BITS   = 12;
  localparam int unsigned SUM_W         = 21;
  localparam int unsigned BYTES_W       = 20;
  localparam int unsigned TOL_W         = 4;
  localparam int unsigned CFG_DATA_W    = 9;
  localparam int unsigned PRODUCT_W     = COUNT_W + TOL_W;

  localparam logic [COUNT_W-1:0] MAX_LIST_WORDS   = COUNT_W'(256);
  localparam logic [COUNT_W-1:0] LIMIT_RESET      = COUNT_W'(5);
  localparam logic [TOL_W-1:0]   TOLERANCE_RESET  = TOL_W'(7);

  typedef enum logic [0:0] {
    REG_SMALL_LIST_LIMIT = 1'b0,
    REG_TOLERANCE_TENTHS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [HASH_W-1:0]  found_hash;
    logic [HASH_W-1:0]  ideal_hash;
    logic [COUNT_W-1:0] found_count;
    logic [COUNT_W-1:0] ideal_count;
    logic               last;
  } pair_t;

  typedef struct packed {
    logic               is_missing;
    logic [INDEX_W-1:0] missing_index;
    logic               done_res;
    logic               matched;
    logic [COUNT_W-1:0] words_correct;
    logic [COUNT_W-1:0] words_total;
    logic [BYTES_W-1:0] bytes_correct;
    logic [BYTES_W-1:0] expected_bytes;
  } result_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pair_index;
    logic [COUNT_W-1:0] equal_count;
    logic [SUM_W-1:0]   bytes_equal_sum;
    logic [SUM_W-1:0]   bytes_expected_sum;
  } acc_t;

  typedef struct packed {
    logic [COUNT_W-1:0] small_list_limit;
    logic [TOL_W-1:0]   tolerance_tenths;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/hash_list_compare.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_list_compare
// Streams received/expected hash pairs and reports missing packets and the
// final list match decision.
// ----------------------------------------------------------------------------
// One pair request is taken every cycle unless result_ready stalls the output;
// each yields exactly one result request through the input and result
// registers. The rate is set by the accumulator loop in hlc_datapath: counts
// and byte sums update in the same cycle a pair leaves the input register.
// The result carrying done_res closes the comparison and the totals restart
// from zero for the next list. pair_ready follows result_ready combinationally
// when both registers are full. Write configuration only while idle.
module hash_list_compare (
  input  var logic                        clk,
  input  var logic                        rst,
  input  var logic                        pair_valid,
  output logic                            pair_ready,
  input  var hlc_pkg::pair_t              pair,
  output logic                            result_valid,
  input  var logic                        result_ready,
  output hlc_pkg::result_t                result,
  input  var logic                        cfg_we,
  input  var hlc_pkg::cfg_index_t         cfg_index,
  input  var logic [hlc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hlc_pkg::*;

  logic    s1_valid;
  pair_t   s1;
  acc_t    acc;
  acc_t    acc_next;
  cfg_t    cfg;
  result_t dp_result;
  logic    advance;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign pair_ready = !s1_valid || advance;

  hlc_datapath u_datapath (
    .pair     (s1),
    .acc      (acc),
    .cfg      (cfg),
    .acc_next (acc_next),
    .result   (dp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      result_valid         <= 1'b0;
      acc                  <= '0;
      cfg.small_list_limit <= LIMIT_RESET;
      cfg.tolerance_tenths <= TOLERANCE_RESET;
    end else begin
      if (pair_ready) begin
        s1_valid <= pair_valid;
      end
      if (advance) begin
        acc          <= acc_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SMALL_LIST_LIMIT: cfg.small_list_limit <= cfg_data[COUNT_W-1:0];
          REG_TOLERANCE_TENTHS: cfg.tolerance_tenths <= cfg_data[TOL_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && pair_ready) begin
      s1 <= pair;
    end
    if (advance) begin
      result <= dp_result;
    end
  end

  // totals stay cleared while a closing result waits
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> acc == '0)
    else $error("accumulators not cleared after last pair");

  // a held input item is never lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1))
    else $error("stalled input register changed");

  // summary fields only on the closing result
  a_summary: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.done_res |-> !result.matched && result.words_total == '0)
    else $error("summary fields set on a non-final result");

endmodule
`default_nettype wire

### hw/rtl/hlc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_datapath
// Per-pair compare, accumulator update and end-of-list match decision.
// ----------------------------------------------------------------------------
module hlc_datapath (
  input  var hlc_pkg::pair_t   pair,
  input  var hlc_pkg::acc_t    acc,
  input  var hlc_pkg::cfg_t    cfg,
  output hlc_pkg::acc_t        acc_next,
  output hlc_pkg::result_t     result
);
  import hlc_pkg::*;

  logic [COUNT_W-1:0]   found_cnt;
  logic [COUNT_W-1:0]   ideal_cnt;
  logic [COUNT_W-1:0]   shorter;
  logic [COUNT_W-1:0]   longer;
  logic                 active;
  logic                 eq;
  logic                 header;
  logic [COUNT_W:0]     eq_inc;
  logic [COUNT_W-1:0]   eq_next;
  logic [SUM_W:0]       exp_add;
  logic [SUM_W:0]       equ_add;
  logic [SUM_W-1:0]     exp_next;
  logic [SUM_W-1:0]     equ_next;
  logic                 strict;
  logic [PRODUCT_W-1:0] eq_times_ten;
  logic [PRODUCT_W-1:0] short_times_tol;
  logic                 match;

  always_comb begin
    found_cnt = (pair.found_count > MAX_LIST_WORDS) ? MAX_LIST_WORDS : pair.found_count;
    ideal_cnt = (pair.ideal_count > MAX_LIST_WORDS) ? MAX_LIST_WORDS : pair.ideal_count;
    shorter   = (found_cnt < ideal_cnt) ? found_cnt : ideal_cnt;
    longer    = (found_cnt < ideal_cnt) ? ideal_cnt : found_cnt;

    active = {1'b0, acc.pair_index} < shorter;
    eq     = pair.found_hash == pair.ideal_hash;
    header = acc.pair_index == '0;

    // saturate the count and byte-sum accumulators
    eq_inc  = {1'b0, acc.equal_count} + (COUNT_W+1)'(1);
    exp_add = {1'b0, acc.bytes_expected_sum}
            + (SUM_W+1)'(pair.ideal_hash[LENGTH_BITS-1:0]);
    equ_add = {1'b0, acc.bytes_equal_sum}
            + (SUM_W+1)'(pair.found_hash[LENGTH_BITS-1:0]);

    eq_next  = acc.equal_count;
    exp_next = acc.bytes_expected_sum;
    equ_next = acc.bytes_equal_sum;
    if (active && eq) begin
      eq_next = eq_inc[COUNT_W] ? '1 : eq_inc[COUNT_W-1:0];
    end
    if (active && !header) begin
      exp_next = exp_add[SUM_W] ? '1 : exp_add[SUM_W-1:0];
      if (eq) begin
        equ_next = equ_add[SUM_W] ? '1 : equ_add[SUM_W-1:0];
      end
    end

    result = '0;
    if (active && !header && !eq) begin
      result.is_missing    = 1'b1;
      result.missing_index = acc.pair_index - INDEX_W'(1);
    end

    strict          = shorter < cfg.small_list_limit;
    eq_times_ten    = (PRODUCT_W'(eq_next) << 3) + (PRODUCT_W'(eq_next) << 1);
    short_times_tol = PRODUCT_W'(shorter) * PRODUCT_W'(cfg.tolerance_tenths);
    if (strict) begin
      match = (longer == shorter) && (eq_next == shorter);
    end else begin
      match = eq_times_ten > short_times_tol;
    end

    acc_next.pair_index         = acc.pair_index + INDEX_W'(1);
    acc_next.equal_count        = eq_next;
    acc_next.bytes_equal_sum    = equ_next;
    acc_next.bytes_expected_sum = exp_next;

    if (pair.last) begin
      result.done_res = 1'b1;
      if (match) begin
        result.matched        = 1'b1;
        result.words_correct  = strict ? shorter : eq_next;
        result.words_total    = strict ? shorter : longer;
        result.bytes_correct  = equ_next[SUM_W-1] ? '1 : equ_next[BYTES_W-1:0];
        result.expected_bytes = exp_next[SUM_W-1] ? '1 : exp_next[BYTES_W-1:0];
      end
      // drop the accumulated list for the next comparison
      acc_next = '0;
    end
  end

endmodule
`default_nettype wire
